// ===== hw/rtl/bre_pkg.sv =====
// ----------------------------------------------------------------------------
// bre_pkg
// Shared types and constants of the block reassembly flag extractor.
// ----------------------------------------------------------------------------
package bre_pkg;

	localparam int STAGE_DEPTH = 4096;
	localparam int DATA_DEPTH  = 65536;
	localparam int STAGE_AW    = $clog2(STAGE_DEPTH);
	localparam int DATA_AW     = $clog2(DATA_DEPTH);

	localparam logic [2:0] EV_STORED    = 3'd0;
	localparam logic [2:0] EV_SUM_BAD   = 3'd1;
	localparam logic [2:0] EV_BLOCK_OOR = 3'd2;
	localparam logic [2:0] EV_FLAG_WORD = 3'd3;
	localparam logic [2:0] EV_FLAG_OOR  = 3'd4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       first_of_file;
	} byte_beat_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [15:0] flag_word;
		logic [15:0] item_index;
		logic        last;
	} res_beat_t;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_REPORT = 2'd1,
		CMD_COPY   = 2'd2,
		CMD_FLAG   = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic                  clear;
		logic [2:0]            ev;
		logic [15:0]           index;
		logic                  last;
		logic [DATA_AW-1:0]    offset;
		logic [STAGE_AW:0]     length;
	} cmd_t;

	typedef struct packed {
		logic                en;
		logic [STAGE_AW-1:0] addr;
		logic [7:0]          data;
	} stage_wr_t;

endpackage

// ===== hw/rtl/bre_parser.sv =====
// ----------------------------------------------------------------------------
// bre_parser
// Byte-level file parser: header, block heads, payload checksum, trailer.
// ----------------------------------------------------------------------------
module bre_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  bre_pkg::byte_beat_t beat,
	output bre_pkg::cmd_t      cmd,
	output bre_pkg::stage_wr_t stage_wr
);
	import bre_pkg::*;

	typedef enum logic [5:0] {
		PH_HEADER  = 6'b000001,
		PH_BHEAD   = 6'b000010,
		PH_PAYLOAD = 6'b000100,
		PH_FCOUNT  = 6'b001000,
		PH_FOFFSET = 6'b010000,
		PH_DONE    = 6'b100000
	} phase_t;

	phase_t      phase_q, ph;
	logic [15:0] cnt_q, c;
	logic [31:0] size_q, sz;
	logic [15:0] blocks_q, bl;
	logic [15:0] idx_q, ix;
	logic [31:0] boff_q, bo;
	logic [15:0] blen_q, ln;
	logic [15:0] ssum_q, ss;
	logic [15:0] rsum_q, rs;
	logic [7:0]  plow_q, pl;
	logic [15:0] flags_q, fl;
	logic [31:0] foff_q, fo;
	logic [32:0] lim;
	logic        fin;
	logic [7:0]  b;

	always_comb begin
		b  = beat.in_byte;
		ph = phase_q; c = cnt_q; sz = size_q; bl = blocks_q; ix = idx_q;
		bo = boff_q; ln = blen_q; ss = ssum_q; rs = rsum_q; pl = plow_q;
		fl = flags_q; fo = foff_q;
		if (beat.first_of_file) begin
			ph = PH_HEADER; c = '0; sz = '0; bl = '0; ix = '0; bo = '0; ln = '0;
			ss = '0; rs = '0; pl = '0; fl = '0; fo = '0;
		end
		lim = ({1'b0, sz} > 33'(DATA_DEPTH)) ? 33'(DATA_DEPTH) : {1'b0, sz};
		fin = 1'b0;
		cmd = '{kind: CMD_NONE, clear: beat.first_of_file, ev: EV_STORED,
			index: ix, last: 1'b0, offset: '0, length: '0};
		stage_wr = '{en: 1'b0, addr: c[STAGE_AW-1:0], data: b};

		case (ph)
			PH_HEADER: begin
				if (c >= 16'd8 && c <= 16'd11)
					sz = {sz[23:0], b};
				else if (c == 16'd12 || c == 16'd13)
					bl = {bl[7:0], b};
				if (c == 16'd15) begin
					c = '0;
					ix = '0;
					ph = (bl == 16'd0) ? PH_FCOUNT : PH_BHEAD;
				end else begin
					c = c + 16'd1;
				end
			end
			PH_BHEAD: begin
				if (c <= 16'd3)
					bo = (c == 16'd0) ? {24'h0, b} : {bo[23:0], b};
				else if (c == 16'd4)
					ss = {8'h0, b};
				else if (c == 16'd5)
					ss = {b, ss[7:0]};
				else if (c == 16'd6)
					ln = {8'h0, b};
				else
					ln = {ln[7:0], b};
				if (c == 16'd7) begin
					rs = '0;
					pl = '0;
					c = '0;
					if (ln == 16'd0)
						fin = 1'b1;
					else
						ph = PH_PAYLOAD;
				end else begin
					c = c + 16'd1;
				end
			end
			PH_PAYLOAD: begin
				stage_wr.en = accept && ({1'b0, c} < 17'(STAGE_DEPTH));
				if (c[0])
					rs = rs ^ {b, pl};
				else
					pl = b;
				if ({1'b0, c} + 17'd1 >= {1'b0, ln})
					fin = 1'b1;
				else
					c = c + 16'd1;
			end
			PH_FCOUNT: begin
				fl = (c == 16'd0) ? {8'h0, b} : {fl[7:0], b};
				if (c == 16'd1) begin
					c = '0;
					ix = '0;
					ph = (fl == 16'd0) ? PH_DONE : PH_FOFFSET;
				end else begin
					c = 16'd1;
				end
			end
			PH_FOFFSET: begin
				fo = (c == 16'd0) ? {24'h0, b} : {fo[23:0], b};
				if (c == 16'd3) begin
					cmd.index = ix;
					if ({1'b0, fo} + 33'd1 < lim) begin
						cmd.kind = CMD_FLAG;
						cmd.ev = EV_FLAG_WORD;
						cmd.offset = fo[DATA_AW-1:0];
					end else begin
						cmd.kind = CMD_REPORT;
						cmd.ev = EV_FLAG_OOR;
					end
					ix = ix + 16'd1;
					fl = fl - 16'd1;
					cmd.last = (fl == 16'd0);
					c = '0;
					if (fl == 16'd0)
						ph = PH_DONE;
				end else begin
					c = c + 16'd1;
				end
			end
			default: begin
			end
		endcase

		if (fin) begin
			if (ln[0])
				rs = rs ^ {8'h0, pl};
			cmd.index = ix;
			cmd.kind = CMD_REPORT;
			if (rs != ss) begin
				cmd.ev = EV_SUM_BAD;
			end else if ({1'b0, ln} > 17'(STAGE_DEPTH) ||
					({1'b0, bo} + {17'h0, ln}) > lim) begin
				cmd.ev = EV_BLOCK_OOR;
			end else begin
				cmd.ev = EV_STORED;
				if (ln != 16'd0) begin
					cmd.kind = CMD_COPY;
					cmd.offset = bo[DATA_AW-1:0];
					cmd.length = ln[STAGE_AW:0];
				end
			end
			ix = ix + 16'd1;
			bl = bl - 16'd1;
			c = '0;
			ph = (bl == 16'd0) ? PH_FCOUNT : PH_BHEAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; cnt_q <= '0; size_q <= '0; blocks_q <= '0;
			idx_q <= '0; boff_q <= '0; blen_q <= '0; ssum_q <= '0; rsum_q <= '0;
			plow_q <= '0; flags_q <= '0; foff_q <= '0;
		end else if (accept) begin
			phase_q <= ph; cnt_q <= c; size_q <= sz; blocks_q <= bl;
			idx_q <= ix; boff_q <= bo; blen_q <= ln; ssum_q <= ss; rsum_q <= rs;
			plow_q <= pl; flags_q <= fl; foff_q <= fo;
		end
	end

endmodule

// ===== hw/rtl/bre_store.sv =====
// ----------------------------------------------------------------------------
// bre_store
// Staging and data memories with the clear, copy and flag read sequencer,
// plus the result register.
// ----------------------------------------------------------------------------
module bre_store (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  bre_pkg::cmd_t       cmd,
	input  bre_pkg::stage_wr_t  stage_wr,
	output logic                busy,
	output logic                res_valid,
	input  logic                res_stall,
	output bre_pkg::res_beat_t  res_data
);
	import bre_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_COPY   = 6'b000100,
		S_FLAG_A = 6'b001000,
		S_FLAG_B = 6'b010000,
		S_FLAG_C = 6'b100000
	} seq_t;

	seq_t                state_q;
	logic [DATA_AW-1:0]  clr_q;
	logic [DATA_AW-1:0]  cp_base_q;
	logic [STAGE_AW:0]   cp_len_q;
	logic [STAGE_AW:0]   rp_q;
	logic                wr_s1;
	logic [DATA_AW-1:0]  wa_s1;
	logic [DATA_AW-1:0]  fo_q;
	logic [7:0]          hi_q;
	res_beat_t           pend_q;
	logic                res_valid_q;
	res_beat_t           res_q;

	logic [7:0]          stage_mem [STAGE_DEPTH];
	logic [7:0]          stage_q;
	logic [7:0]          data_mem [DATA_DEPTH];
	logic [7:0]          st_q;

	logic                st_we;
	logic [DATA_AW-1:0]  st_wa;
	logic [7:0]          st_wd;
	logic [DATA_AW-1:0]  st_ra;
	logic                rd_issue;
	logic                res_load;

	assign busy      = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res_data  = res_q;
	assign rd_issue  = (state_q == S_COPY) && (rp_q != cp_len_q);
	// A new result enters the output register on a report or copy command, or a finished flag read.
	assign res_load  = ((state_q == S_IDLE) && accept &&
		(cmd.kind == CMD_REPORT || cmd.kind == CMD_COPY)) || (state_q == S_FLAG_C);

	always_ff @(posedge clk) begin
		if (stage_wr.en)
			stage_mem[stage_wr.addr] <= stage_wr.data;
		stage_q <= stage_mem[rp_q[STAGE_AW-1:0]];
	end

	always_comb begin
		st_we = 1'b0;
		st_wa = wa_s1;
		st_wd = stage_q;
		st_ra = fo_q;
		case (state_q)
			S_CLEAR: begin
				st_we = 1'b1;
				st_wa = clr_q;
				st_wd = 8'h00;
			end
			S_COPY:   st_we = wr_s1;
			S_FLAG_B: st_ra = fo_q + DATA_AW'(1);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we)
			data_mem[st_wa] <= st_wd;
		st_q <= data_mem[st_ra];
	end

	always_ff @(posedge clk) begin
		wa_s1 <= cp_base_q + DATA_AW'(rp_q);
		hi_q  <= st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cp_base_q   <= '0;
			cp_len_q    <= '0;
			rp_q        <= '0;
			wr_s1       <= 1'b0;
			fo_q        <= '0;
			pend_q      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			wr_s1 <= rd_issue;
			if (res_load)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + DATA_AW'(1);
					if (clr_q == DATA_AW'(DATA_DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						case (cmd.kind)
							CMD_REPORT, CMD_COPY: begin
								res_q <= '{event_res: cmd.ev, flag_word: 16'h0,
									item_index: cmd.index, last: cmd.last};
								if (cmd.kind == CMD_COPY) begin
									cp_base_q <= cmd.offset;
									cp_len_q  <= cmd.length;
									rp_q      <= '0;
									state_q   <= S_COPY;
								end
							end
							CMD_FLAG: begin
								fo_q    <= cmd.offset;
								pend_q  <= '{event_res: cmd.ev, flag_word: 16'h0,
									item_index: cmd.index, last: cmd.last};
								state_q <= S_FLAG_A;
							end
							default: begin
								if (cmd.clear) begin
									clr_q   <= '0;
									state_q <= S_CLEAR;
								end
							end
						endcase
					end
				end
				S_COPY: begin
					if (rd_issue)
						rp_q <= rp_q + (STAGE_AW + 1)'(1);
					else if (!wr_s1)
						state_q <= S_IDLE;
				end
				S_FLAG_A: state_q <= S_FLAG_B;
				S_FLAG_B: state_q <= S_FLAG_C;
				S_FLAG_C: begin
					res_q <= '{event_res: pend_q.event_res, flag_word: {hi_q, st_q},
						item_index: pend_q.item_index, last: pend_q.last};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/block_reassembly_flag_extractor.sv =====
// ----------------------------------------------------------------------------
// block_reassembly_flag_extractor
// Parses a byte stream into header, checksummed blocks and a flag trailer;
// reassembles verified blocks into a data store and reports flag words.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat type    Handshake
//  byte      in         byte_beat_t  byte_valid / byte_stall
//  res       out        res_beat_t   res_valid / res_stall
//
// An ordinary byte does not hold the input. A non-empty block that passes its checks
// holds the input while the staging memory is copied into the data store, one
// byte per cycle through the store's single write port. An in-range flag holds
// the input through S_FLAG_A, S_FLAG_B and S_FLAG_C, two reads of the store's
// one read port. After reset and after every byte marked first_of_file, the
// data store is cleared one entry per cycle, all DATA_DEPTH (65536) entries, with
// the input stalled. A result waiting in the output register stalls the input
// only while the downstream side stalls it.
//
module block_reassembly_flag_extractor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  bre_pkg::byte_beat_t byte_data,
	output logic                res_valid,
	input  logic                res_stall,
	output bre_pkg::res_beat_t  res_data
);
	import bre_pkg::*;

	logic      accept;
	logic      busy;
	cmd_t      cmd;
	stage_wr_t stage_wr;

	// Hold off new bytes while the sequencer works or the result slot is blocked.
	assign byte_stall = busy | (res_valid & res_stall);
	assign accept     = byte_valid & ~byte_stall;

	bre_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.beat     (byte_data),
		.cmd      (cmd),
		.stage_wr (stage_wr)
	);

	bre_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd),
		.stage_wr  (stage_wr),
		.busy      (busy),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule
